// ===== rtl/htsd_pkg.sv =====
package htsd_pkg;

  // Default sizes
  localparam int MAX_NODES_DEF   = 511;
  localparam int STACK_DEPTH_DEF = 256;

  // Character codes
  localparam logic [7:0] CH_LEAF = 8'h31;  // '1'
  localparam logic [7:0] CH_LEFT = 8'h30;  // '0'
  localparam logic [7:0] CH_SEP  = 8'h7C;  // '|'

  // Parse phases
  localparam logic [1:0] PH_TREE = 2'd0;
  localparam logic [1:0] PH_DONE = 2'd1;
  localparam logic [1:0] PH_BITS = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NO_SEP = 2'd1;
  localparam logic [1:0] ST_BAD    = 2'd2;

endpackage

// ===== rtl/huffman_tree_stream_decoder_core.sv =====
// Huffman stream decoder with a preorder code tree.
// Input channel: item_valid / item_stall carry char_in and final_char, one
// character of the compressed text per word. Characters before the first
// '|' rebuild the code tree into a node table memory; later characters are
// code bits ('0' left, anything else right).
// Output channel: result_valid / result_stall carry symbol_out, symbol_valid,
// message_end and status. A word is produced when a leaf is reached or when
// final_char is set; other characters produce nothing.
// Each character is read from the input register in state S_P1 and finished
// in state S_P2 from the registered read of the node table (one read per
// code bit, each depending on the last); the next character is accepted only
// as the current one finishes. The result word is registered in the output
// register at the end of S_P2. The output register lets the next character
// be accepted while a result still waits; a stalled result holds, and a
// character that needs the output waits in S_P2 until the register frees up.
// Reset (rst, synchronous) clears all control state; the node table and
// stack memories are not cleared and need no clearing pass. After the word
// with message_end the block returns to its reset state for the next text.
module huffman_tree_stream_decoder_core
  import htsd_pkg::*;
#(
  parameter int MAX_NODES   = MAX_NODES_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [7:0] char_in,
  input  logic       final_char,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] symbol_out,
  output logic       symbol_valid,
  output logic       message_end,
  output logic [1:0] status
);

  localparam int NW  = $clog2(MAX_NODES);
  localparam int LW  = (NW < 8) ? 8 : NW;
  localparam int EW  = 1 + LW + NW;
  localparam int NCW = $clog2(MAX_NODES + 1);
  localparam int SAW = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;
  localparam int SDW = $clog2(STACK_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_P1   = 2'd1;
  localparam logic [1:0] S_P2   = 2'd2;

  // Memories
  logic [EW-1:0]   node_mem  [MAX_NODES];
  logic [2*NW-1:0] stack_mem [STACK_DEPTH];
  logic [EW-1:0]   node_rd;
  logic [2*NW-1:0] stack_rd;

  // Registers
  logic [1:0]     st, st_next;
  logic [7:0]     ch;
  logic           last;
  logic [1:0]     phase, phase_next;
  logic           exp_leaf, exp_leaf_next;
  logic           root_present, root_present_next;
  logic           err, err_next;
  logic [SDW-1:0] sd, sd_next;
  logic [NCW-1:0] nc, nc_next;
  logic [NW-1:0]  top_idx, top_idx_next;
  logic [NW-1:0]  top_left, top_left_next;
  logic           top_has_left, top_has_left_next;
  logic [EW-1:0]  cur_entry, cur_entry_next;
  logic [EW-1:0]  root_entry;
  logic           pend_par, pend_par_next;
  logic [NW-1:0]  par_addr, par_addr_next;
  logic [EW-1:0]  par_data, par_data_next;
  logic           reload, reload_next;
  logic           dec_go, dec_go_next;
  logic           lone, lone_next;
  logic           nxt_zero, nxt_zero_next;

  // Memory port controls
  logic            nt_we, nt_re, sk_we, sk_re;
  logic [NW-1:0]   nt_wa, nt_ra;
  logic [EW-1:0]   nt_wd;
  logic [SAW-1:0]  sk_wa, sk_ra;
  logic [2*NW-1:0] sk_wd;

  // Result
  logic       emit, needs_out, fin, accept;
  logic [7:0] sym;
  logic [1:0] stat;

  assign accept     = item_valid && !item_stall;
  assign needs_out  = emit || last;
  assign fin        = (st == S_P2) && (!needs_out || !result_valid || !result_stall);
  assign item_stall = !((st == S_IDLE) || fin);

  // Sequencer and state update
  always_comb begin
    logic           leaf;
    logic           do_add;
    logic           popped;
    logic [SDW-1:0] sd_tmp;
    logic [NW-1:0]  idx;
    logic [NW-1:0]  nxt;

    leaf   = 1'b0;
    do_add = 1'b0;
    popped = 1'b0;
    sd_tmp = sd;
    idx    = nc[NW-1:0];
    nxt    = (ch == CH_LEFT) ? cur_entry[NW +: NW] : cur_entry[NW-1:0];

    st_next           = st;
    phase_next        = phase;
    exp_leaf_next     = exp_leaf;
    root_present_next = root_present;
    err_next          = err;
    sd_next           = sd;
    nc_next           = nc;
    top_idx_next      = top_idx;
    top_left_next     = top_left;
    top_has_left_next = top_has_left;
    cur_entry_next    = cur_entry;
    pend_par_next     = pend_par;
    par_addr_next     = par_addr;
    par_data_next     = par_data;
    reload_next       = reload;
    dec_go_next       = dec_go;
    lone_next         = lone;
    nxt_zero_next     = nxt_zero;

    nt_we = 1'b0;
    nt_wa = '0;
    nt_wd = '0;
    nt_re = 1'b0;
    nt_ra = nxt;
    sk_we = 1'b0;
    sk_wa = '0;
    sk_wd = '0;
    sk_re = 1'b0;
    sk_ra = '0;

    emit = 1'b0;
    sym  = 8'd0;
    stat = ST_OK;

    unique case (st)
      S_IDLE: begin
        if (accept) st_next = S_P1;
      end
      S_P1: begin
        st_next       = S_P2;
        pend_par_next = 1'b0;
        reload_next   = 1'b0;
        dec_go_next   = 1'b0;
        lone_next     = 1'b0;
        if (phase == PH_BITS) begin
          // Issue the child read for this bit
          if (!err && root_present) begin
            if (root_entry[EW-1]) begin
              lone_next = 1'b1;
            end else begin
              dec_go_next   = 1'b1;
              nxt_zero_next = (nxt == '0);
              nt_re         = 1'b1;
            end
          end
        end else if (ch == CH_SEP) begin
          if (phase == PH_TREE && (exp_leaf || sd != '0 || !root_present)) err_next = 1'b1;
          phase_next     = PH_BITS;
          exp_leaf_next  = 1'b0;
          cur_entry_next = root_entry;
        end else if (phase == PH_TREE) begin
          if (exp_leaf) begin
            exp_leaf_next = 1'b0;
            do_add        = 1'b1;
            leaf          = 1'b1;
          end else if (ch == CH_LEAF) begin
            exp_leaf_next = 1'b1;
          end else begin
            do_add = 1'b1;
          end
        end

        // Add a node to the table and attach it to the open parent
        if (do_add) begin
          if (nc >= NCW'(MAX_NODES)) begin
            err_next      = 1'b1;
            phase_next    = PH_DONE;
            exp_leaf_next = 1'b0;
          end else begin
            nc_next = nc + NCW'(1);
            if (leaf) begin
              nt_we = 1'b1;
              nt_wa = idx;
              nt_wd = {1'b1, LW'(ch), NW'(0)};
            end
            if (!root_present) begin
              root_present_next = 1'b1;
            end else if (sd != '0) begin
              if (!top_has_left) begin
                top_has_left_next = 1'b1;
                top_left_next     = idx;
              end else begin
                pend_par_next = 1'b1;
                par_addr_next = top_idx;
                par_data_next = {1'b0, LW'(top_left), idx};
                popped        = 1'b1;
                sd_tmp        = sd - SDW'(1);
              end
            end
            if (!leaf) begin
              if (sd_tmp >= SDW'(STACK_DEPTH)) begin
                err_next      = 1'b1;
                phase_next    = PH_DONE;
                exp_leaf_next = 1'b0;
                sd_next       = sd_tmp;
              end else begin
                if (!popped && sd_tmp != '0) begin
                  sk_we = 1'b1;
                  sk_wa = SAW'(sd_tmp - SDW'(1));
                  sk_wd = {top_idx, idx};
                end
                top_idx_next      = idx;
                top_has_left_next = 1'b0;
                sd_next           = sd_tmp + SDW'(1);
                if (sd_tmp + SDW'(1) == '0) phase_next = PH_DONE;
              end
            end else begin
              sd_next = sd_tmp;
              if (popped && sd_tmp != '0) begin
                sk_re       = 1'b1;
                sk_ra       = SAW'(sd_tmp - SDW'(1));
                reload_next = 1'b1;
              end
              if (sd_tmp == '0) phase_next = PH_DONE;
            end
          end
        end
      end
      S_P2: begin
        // Finish the bit from the registered read; write the pending parent and reload the stack top
        if (lone) begin
          emit = 1'b1;
          sym  = root_entry[NW +: 8];
        end else if (dec_go) begin
          if (nxt_zero) begin
            err_next       = 1'b1;
            cur_entry_next = root_entry;
          end else if (node_rd[EW-1]) begin
            emit           = 1'b1;
            sym            = node_rd[NW +: 8];
            cur_entry_next = root_entry;
          end else begin
            cur_entry_next = node_rd;
          end
        end
        if (last) begin
          if (phase != PH_BITS) stat = ST_NO_SEP;
          else if (err_next)    stat = ST_BAD;
          else                  stat = ST_OK;
        end
        if (pend_par && fin) begin
          nt_we = 1'b1;
          nt_wa = par_addr;
          nt_wd = par_data;
        end
        if (reload) begin
          top_idx_next      = stack_rd[2*NW-1:NW];
          top_left_next     = stack_rd[NW-1:0];
          top_has_left_next = 1'b1;
        end
        if (fin) begin
          pend_par_next = 1'b0;
          reload_next   = 1'b0;
          st_next       = accept ? S_P1 : S_IDLE;
          if (last) begin
            phase_next        = PH_TREE;
            exp_leaf_next     = 1'b0;
            root_present_next = 1'b0;
            err_next          = 1'b0;
            sd_next           = '0;
            nc_next           = '0;
          end
        end else begin
          // hold everything until the output frees up
          err_next          = err;
          cur_entry_next    = cur_entry;
          top_idx_next      = top_idx;
          top_left_next     = top_left;
          top_has_left_next = top_has_left;
        end
      end
      default: st_next = S_IDLE;
    endcase
  end

  // Node table memory
  always_ff @(posedge clk) begin
    if (nt_we) node_mem[nt_wa] <= nt_wd;
    if (nt_re) node_rd <= node_mem[nt_ra];
  end

  // Open node stack memory
  always_ff @(posedge clk) begin
    if (sk_we) stack_mem[sk_wa] <= sk_wd;
    if (sk_re) stack_rd <= stack_mem[sk_ra];
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      ch   <= char_in;
      last <= final_char;
    end
    if (nt_we && nt_wa == '0) root_entry <= nt_wd;
    top_idx   <= top_idx_next;
    top_left  <= top_left_next;
    cur_entry <= cur_entry_next;
    par_addr  <= par_addr_next;
    par_data  <= par_data_next;
    nxt_zero  <= nxt_zero_next;
    if (fin && needs_out) begin
      symbol_out   <= sym;
      symbol_valid <= emit;
      message_end  <= last;
      status       <= stat;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= S_IDLE;
      phase        <= PH_TREE;
      exp_leaf     <= 1'b0;
      root_present <= 1'b0;
      err          <= 1'b0;
      sd           <= '0;
      nc           <= '0;
      top_has_left <= 1'b0;
      pend_par     <= 1'b0;
      reload       <= 1'b0;
      dec_go       <= 1'b0;
      lone         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      st           <= st_next;
      phase        <= phase_next;
      exp_leaf     <= exp_leaf_next;
      root_present <= root_present_next;
      err          <= err_next;
      sd           <= sd_next;
      nc           <= nc_next;
      top_has_left <= top_has_left_next;
      pend_par     <= pend_par_next;
      reload       <= reload_next;
      dec_go       <= dec_go_next;
      lone         <= lone_next;
      if (fin && needs_out)              result_valid <= 1'b1;
      else if (result_valid && !result_stall) result_valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/htsd_checker.sv =====
module htsd_checker
  import htsd_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       result_valid,
  input logic       result_stall,
  input logic [7:0] symbol_out,
  input logic       symbol_valid,
  input logic       message_end,
  input logic [1:0] status
);

  // Hold a stalled word
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(symbol_out)
      && $stable(status) && $stable(message_end))
    else $error("stalled result word changed");

  // Every word carries a symbol or ends the text
  a_reason: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> symbol_valid || message_end)
    else $error("result word without symbol or end");

  // Status only on the closing word
  a_status: assert property (@(posedge clk) disable iff (rst)
    result_valid && !message_end |-> status == ST_OK)
    else $error("status set before end of text");

  // No undefined status code
  a_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> status == ST_OK || status == ST_NO_SEP || status == ST_BAD)
    else $error("undefined status code");

  // Drop symbol byte when no symbol
  a_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !symbol_valid |-> symbol_out == 8'd0)
    else $error("symbol byte set without symbol");

endmodule

bind huffman_tree_stream_decoder_core htsd_checker u_htsd_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .symbol_out   (symbol_out),
  .symbol_valid (symbol_valid),
  .message_end  (message_end),
  .status       (status)
);

// ===== verif/tb.sv =====
module tb;
  import htsd_pkg::*;

  localparam int MAX_CYCLES = 600000;

  typedef struct packed {
    logic [7:0] sym;
    logic       sym_ok;
    logic       msg_end;
    logic [1:0] stat;
  } word_t;

  // Scoreboard: tracks the decoder state and queues the predicted words
  class decode_scoreboard;
    logic       node_leaf  [MAX_NODES_DEF];
    logic [9:0] node_left  [MAX_NODES_DEF];
    logic [9:0] node_right [MAX_NODES_DEF];
    logic [9:0] open_stack [STACK_DEPTH_DEF];
    int unsigned depth, count, cur;
    logic [1:0] ph;
    bit want_leaf, have_root, err;
    word_t pending_words[$];
    int errors;

    function void clear_state();
      depth = 0; count = 0; cur = 0; ph = PH_TREE;
      want_leaf = 0; have_root = 0; err = 0;
    endfunction

    function void stop_tree();
      err = 1; ph = PH_DONE; want_leaf = 0;
    endfunction

    function void grow_tree(bit leaf, logic [7:0] b);
      int unsigned idx, parent;
      if (count >= MAX_NODES_DEF) begin
        stop_tree();
        return;
      end
      idx = count; count++;
      node_leaf[idx]  = leaf;
      node_left[idx]  = leaf ? {2'b0, b} : 10'd0;
      node_right[idx] = 10'd0;
      // hang the new node under the innermost open internal node
      if (!have_root) begin
        have_root = 1;
      end else if (depth > 0) begin
        parent = 32'(open_stack[depth-1]);
        if (node_left[parent] == 0) begin
          node_left[parent] = 10'(idx);
        end else begin
          node_right[parent] = 10'(idx);
          depth--;
        end
      end
      if (!leaf) begin
        if (depth >= STACK_DEPTH_DEF) begin
          stop_tree();
          return;
        end
        open_stack[depth] = 10'(idx); depth++;
      end
      if (depth == 0) ph = PH_DONE;
    endfunction

    function void note_char(logic [7:0] ch, logic fin);
      bit emit;
      logic [7:0] sym;
      int unsigned nxt;
      word_t w;
      emit = 0; sym = 8'd0;
      if (ph == PH_BITS) begin
        // walk the tree one code bit at a time
        if (!err && have_root) begin
          if (node_leaf[0]) begin
            emit = 1; sym = node_left[0][7:0];
          end else begin
            nxt = (ch == CH_LEFT) ? 32'(node_left[cur]) : 32'(node_right[cur]);
            if (nxt == 0 || nxt >= MAX_NODES_DEF) begin
              err = 1; cur = 0;
            end else if (node_leaf[nxt]) begin
              emit = 1; sym = node_left[nxt][7:0]; cur = 0;
            end else begin
              cur = nxt;
            end
          end
        end
      end else if (ch == CH_SEP) begin
        if (ph == PH_TREE && (want_leaf || depth > 0 || !have_root)) err = 1;
        ph = PH_BITS; want_leaf = 0; cur = 0;
      end else if (ph == PH_TREE) begin
        if (want_leaf) begin
          want_leaf = 0;
          grow_tree(1, ch);
        end else if (ch == CH_LEAF) begin
          want_leaf = 1;
        end else begin
          grow_tree(0, 8'd0);
        end
      end
      if (!emit && !fin) return;
      w.sym = sym; w.sym_ok = emit; w.msg_end = fin; w.stat = ST_OK;
      if (fin) begin
        w.stat = (ph != PH_BITS) ? ST_NO_SEP : (err ? ST_BAD : ST_OK);
        clear_state();
      end
      pending_words.push_back(w);
    endfunction

    function void check_word(word_t got);
      word_t exp_w;
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word %h", $time, got);
        errors++;
        return;
      end
      exp_w = pending_words.pop_front();
      if (got.sym != exp_w.sym) begin
        $display("%0t: symbol_out expected %h actual %h", $time, exp_w.sym, got.sym);
        errors++;
      end
      if (got.sym_ok != exp_w.sym_ok) begin
        $display("%0t: symbol_valid expected %b actual %b", $time, exp_w.sym_ok, got.sym_ok);
        errors++;
      end
      if (got.msg_end != exp_w.msg_end) begin
        $display("%0t: message_end expected %b actual %b", $time, exp_w.msg_end,
                 got.msg_end);
        errors++;
      end
      if (got.stat != exp_w.stat) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_w.stat, got.stat);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 0;
  logic       rst = 1;
  logic       item_valid = 0;
  logic       item_stall;
  logic [7:0] char_in = 8'd0;
  logic       final_char = 0;
  logic       result_valid;
  logic       result_stall = 0;
  logic [7:0] symbol_out;
  logic       symbol_valid;
  logic       message_end;
  logic [1:0] status;

  decode_scoreboard sb = new();
  int sent;
  int cycles;
  int stall_left;
  bit stall_mode;

  huffman_tree_stream_decoder_core u_dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .char_in(char_in), .final_char(final_char),
    .result_valid(result_valid), .result_stall(result_stall),
    .symbol_out(symbol_out), .symbol_valid(symbol_valid),
    .message_end(message_end), .status(status)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Bound the run
  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Stall the output in bursts, with quiet stretches
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = ($urandom_range(0, 3) == 0);
      stall_left = $urandom_range(5, 60);
    end else begin
      stall_left--;
    end
    if (!stall_mode) result_stall <= 1'b0;
    else if ($urandom_range(0, 19) == 0) result_stall <= 1'b1 ^ ($urandom_range(0, 3) == 0);
    else result_stall <= ($urandom_range(0, 2) == 0);
  end

  // Check every accepted word
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      sb.check_word({symbol_out, symbol_valid, message_end, status});
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Send one word and hold it until accepted
  task automatic send_char(logic [7:0] ch, logic fin);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    char_in    <= ch;
    final_char <= fin;
    do @(posedge clk); while (item_stall);
    sb.note_char(ch, fin);
    sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  function automatic logic [7:0] tree_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_SEP);
    return b;
  endfunction

  // Well-formed message: random preorder tree, then random code bits
  task automatic send_message(int max_leaves, int nbits);
    int open_slots, leaves;
    logic [7:0] c;
    open_slots = 1; leaves = 0;
    while (open_slots > 0) begin
      if (leaves + open_slots >= max_leaves || $urandom_range(0, 1)) begin
        send_char(CH_LEAF, 0);
        send_char(tree_byte(), 0);
        open_slots--; leaves++;
      end else begin
        do c = 8'($urandom_range(0, 255)); while (c == CH_SEP || c == CH_LEAF);
        send_char(c, 0);
        open_slots++;
      end
    end
    if ($urandom_range(0, 4) == 0) send_char(tree_byte(), 0);
    send_char(CH_SEP, 0);
    for (int i = 0; i < nbits; i++) begin
      c = $urandom_range(0, 1) ? CH_LEFT : 8'($urandom_range(0, 255));
      send_char(c, i == nbits - 1);
    end
  endtask

  // Broken message: mostly tree-significant characters, random end
  task automatic send_noise(int n);
    logic [7:0] c;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      c = (r < 3) ? CH_LEFT : (r < 6) ? CH_LEAF : (r < 7) ? CH_SEP :
          8'($urandom_range(0, 255));
      send_char(c, i == n - 1);
    end
  endtask

  initial begin
    sb.clear_state();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // lone leaf root, leaf bytes at both extremes, stray chars after tree
    send_text("1A|0x");
    send_char(CH_LEFT, 0); send_char(CH_LEAF, 0); send_char(8'h00, 0);
    send_char(CH_LEAF, 0); send_char(8'hFF, 0); send_char(8'h55, 0);
    send_char(CH_SEP, 0); send_char(CH_LEFT, 0); send_char(8'hFF, 1);
    send_text("|");
    send_text("01a");
    send_text("01a|01");
    send_text("1|0");
    // overflow of the stack of open nodes
    for (int i = 0; i < STACK_DEPTH_DEF + 1; i++) send_char(CH_LEFT, 0);
    send_text("|00");
    // overflow of the node table
    for (int i = 0; i < MAX_NODES_DEF / 2 + 2; i++) begin
      send_char(CH_LEFT, 0); send_char(CH_LEAF, 0); send_char(8'h41, 0);
    end
    send_text("|1");

    while (sent < 1300) begin
      if ($urandom_range(0, 6) == 0) send_noise($urandom_range(1, 12));
      else if ($urandom_range(0, 9) == 0) send_message(40, $urandom_range(20, 80));
      else send_message($urandom_range(1, 8), $urandom_range(1, 40));
    end
    item_valid <= 1'b0;

    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule

// ===== huffman_tree_stream_decoder_core.f =====
rtl/htsd_pkg.sv
rtl/huffman_tree_stream_decoder_core.sv
rtl/htsd_checker.sv
verif/tb.sv
